// File: rtl/ralu_pkg.sv
// ralu_pkg: types, constants and codes shared by the R-type ALU block.
// No dependencies; every other file imports this package.
package ralu_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned RegAw   = 5;
  localparam int unsigned NumRegs = 32;
  localparam int unsigned FnW     = 6;
  localparam int unsigned OpW     = 6;

  // executable fetch window, [WinLo, WinHi)
  localparam logic [DataW-1:0] WinLo   = 32'h1000_0000;
  localparam logic [DataW-1:0] WinHi   = 32'h1100_0000;
  localparam logic [DataW-1:0] LinkOfs = 32'd8;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StOvf    = 2'd1,
    StFault  = 2'd2,
    StUnimpl = 2'd3
  } status_e;

  typedef enum logic [FnW-1:0] {
    FnSll  = 6'd0,
    FnSrl  = 6'd2,
    FnSra  = 6'd3,
    FnSllv = 6'd4,
    FnSrlv = 6'd6,
    FnSrav = 6'd7,
    FnJr   = 6'd8,
    FnJalr = 6'd9,
    FnMfhi = 6'd16,
    FnMthi = 6'd17,
    FnMflo = 6'd18,
    FnMtlo = 6'd19,
    FnAdd  = 6'd32,
    FnAddu = 6'd33,
    FnSub  = 6'd34,
    FnSubu = 6'd35,
    FnAnd  = 6'd36,
    FnOr   = 6'd37,
    FnXor  = 6'd38,
    FnSlt  = 6'd42,
    FnSltu = 6'd43
  } funct_e;

  // register file write from the execute stage
  typedef struct packed {
    logic             we;
    logic [RegAw-1:0] rd;
    logic [DataW-1:0] data;
  } commit_t;

  // one result item
  typedef struct packed {
    status_e          status;
    logic             write_enable;
    logic [RegAw-1:0] dest_reg;
    logic [DataW-1:0] write_value;
    logic             jump_taken;
    logic [DataW-1:0] jump_target;
  } result_t;

endpackage

// File: rtl/ralu_in_if.sv
// ralu_in_if: valid/ready channel carrying one instruction item.
// Depends on ralu_pkg for widths.
interface ralu_in_if import ralu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] instruction;
  logic [DataW-1:0] pc;

  modport source (output valid, output instruction, output pc, input ready);
  modport sink   (input valid, input instruction, input pc, output ready);
endinterface

// File: rtl/ralu_out_if.sv
// ralu_out_if: valid/ready channel carrying one execution result item.
// Depends on ralu_pkg for widths.
interface ralu_out_if import ralu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             write_enable;
  logic [RegAw-1:0] dest_reg;
  logic [DataW-1:0] write_value;
  logic             jump_taken;
  logic [DataW-1:0] jump_target;

  modport source (output valid, output status, output write_enable, output dest_reg,
                  output write_value, output jump_taken, output jump_target,
                  input ready);
  modport sink   (input valid, input status, input write_enable, input dest_reg,
                  input write_value, input jump_taken, input jump_target,
                  output ready);
endinterface

// File: rtl/ralu_regfile.sv
// ralu_regfile: 32x32 general register file, two registered read ports,
// one write port, per-entry valid bits and write-to-read bypass. Uses ralu_pkg.
module ralu_regfile import ralu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [RegAw-1:0] rs_addr_i,
  input  logic [RegAw-1:0] rt_addr_i,
  input  commit_t          wr_i,
  output logic [DataW-1:0] rs_data_o,
  output logic [DataW-1:0] rt_data_o
);

  logic [DataW-1:0] mem_q [NumRegs];
  logic [NumRegs-1:0] vld_q;
  logic [DataW-1:0] rs_mem_q, rt_mem_q, fwd_q;
  logic rs_vld_q, rt_vld_q, rs_byp_q, rt_byp_q;

  // storage array and registered read data
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.rd] <= wr_i.data;
    end
    if (rd_en_i) begin
      rs_mem_q <= mem_q[rs_addr_i];
      rt_mem_q <= mem_q[rt_addr_i];
      fwd_q    <= wr_i.data;
    end
  end

  // valid bits: an entry never written reads zero; register 0 is never set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rs_vld_q <= 1'b0;
      rt_vld_q <= 1'b0;
      rs_byp_q <= 1'b0;
      rt_byp_q <= 1'b0;
    end else begin
      if (wr_i.we && (wr_i.rd != '0)) begin
        vld_q[wr_i.rd] <= 1'b1;
      end
      if (rd_en_i) begin
        rs_vld_q <= vld_q[rs_addr_i];
        rt_vld_q <= vld_q[rt_addr_i];
        // same-edge write wins over the old array contents
        rs_byp_q <= wr_i.we && (wr_i.rd == rs_addr_i);
        rt_byp_q <= wr_i.we && (wr_i.rd == rt_addr_i);
      end
    end
  end

  assign rs_data_o = rs_byp_q ? fwd_q : (rs_vld_q ? rs_mem_q : '0);
  assign rt_data_o = rt_byp_q ? fwd_q : (rt_vld_q ? rt_mem_q : '0);

endmodule

// File: rtl/ralu_exec.sv
// ralu_exec: decode and ALU for one R-type item, plus the HI and LO words.
// Uses ralu_pkg; operands come from ralu_regfile.
module ralu_exec import ralu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [DataW-1:0] ins_i,
  input  logic [DataW-1:0] pc_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output result_t          res_o,
  output commit_t          commit_o
);

  logic [DataW-1:0] hi_q, lo_q;
  logic [RegAw-1:0] rd, sh, va;
  logic [FnW-1:0]   fn;
  logic [DataW-1:0] sum, diff, val;
  logic             wr, keep, hi_we, lo_we, jump;
  status_e          status;

  assign rd   = ins_i[15:11];
  assign sh   = ins_i[10:6];
  assign fn   = ins_i[FnW-1:0];
  assign va   = a_i[RegAw-1:0];
  assign sum  = a_i + b_i;
  assign diff = a_i - b_i;

  // decode and operate
  always_comb begin
    status = StOk;
    wr     = 1'b0;
    val    = '0;
    jump   = 1'b0;
    hi_we  = 1'b0;
    lo_we  = 1'b0;
    if ((pc_i < WinLo) || (pc_i >= WinHi)) begin
      status = StFault;
    end else if (ins_i[DataW-1 -: OpW] != '0) begin
      status = StUnimpl;
    end else begin
      unique case (funct_e'(fn))
        FnAdd: begin
          if ((~(a_i ^ b_i) & (a_i ^ sum)) >> (DataW-1) != '0) begin
            status = StOvf;
          end else begin
            val = sum;
            wr  = 1'b1;
          end
        end
        FnSub: begin
          if (((a_i ^ b_i) & (a_i ^ diff)) >> (DataW-1) != '0) begin
            status = StOvf;
          end else begin
            val = diff;
            wr  = 1'b1;
          end
        end
        FnAddu: begin val = sum;        wr = 1'b1; end
        FnSubu: begin val = diff;       wr = 1'b1; end
        FnAnd:  begin val = a_i & b_i;  wr = 1'b1; end
        FnOr:   begin val = a_i | b_i;  wr = 1'b1; end
        FnXor:  begin val = a_i ^ b_i;  wr = 1'b1; end
        FnSll:  begin val = b_i << sh;  wr = 1'b1; end
        FnSrl:  begin val = b_i >> sh;  wr = 1'b1; end
        FnSra:  begin val = DataW'($signed(b_i) >>> sh); wr = 1'b1; end
        FnSllv: begin val = b_i << va;  wr = 1'b1; end
        FnSrlv: begin val = b_i >> va;  wr = 1'b1; end
        FnSrav: begin val = DataW'($signed(b_i) >>> va); wr = 1'b1; end
        FnSlt:  begin val = DataW'($signed(a_i) < $signed(b_i)); wr = 1'b1; end
        FnSltu: begin val = DataW'(a_i < b_i); wr = 1'b1; end
        FnMfhi: begin val = hi_q; wr = 1'b1; end
        FnMflo: begin val = lo_q; wr = 1'b1; end
        FnMthi: hi_we = 1'b1;
        FnMtlo: lo_we = 1'b1;
        FnJr:   jump = 1'b1;
        FnJalr: begin jump = 1'b1; val = pc_i + LinkOfs; wr = 1'b1; end
        default: status = StUnimpl;
      endcase
    end
  end

  // writes to register 0 are dropped and reported as no write
  assign keep = wr && (rd != '0);

  always_comb begin
    res_o.status       = status;
    res_o.write_enable = keep;
    res_o.dest_reg     = keep ? rd : '0;
    res_o.write_value  = keep ? val : '0;
    res_o.jump_taken   = jump;
    res_o.jump_target  = jump ? a_i : '0;
    commit_o.we        = fire_i && keep;
    commit_o.rd        = rd;
    commit_o.data      = val;
  end

  // HI and LO words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      lo_q <= '0;
    end else if (fire_i) begin
      if (hi_we) hi_q <= a_i;
      if (lo_we) lo_q <= a_i;
    end
  end

endmodule

// File: rtl/rtype_alu_with_register_file.sv
// R-type execute block with its own 32x32 register file and HI/LO words.
// Takes one instruction item per clock. An accepted item enters the operand
// stage, where the two register reads come back registered, and its result
// is captured in the output register when that stage advances. Throughput
// is one item per cycle as long as results are taken; a stalled output
// holds one result plus one item in the operand stage. A result written
// back to the register file is forwarded to an item read on the same edge,
// so back-to-back dependent instructions see the new value. All registers,
// HI and LO read zero after reset. Depends on ralu_pkg, ralu_in_if,
// ralu_out_if, ralu_regfile and ralu_exec.
module rtype_alu_with_register_file import ralu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ralu_in_if.sink    in_i,
  ralu_out_if.source out_o
);

  logic             s1_vld_q, s1_vld_d, s1_adv, accept;
  logic [DataW-1:0] s1_ins_q, s1_pc_q;
  logic [DataW-1:0] rs_data, rt_data;
  logic             out_vld_q;
  result_t          out_res_q, exec_res;
  commit_t          commit;

  // handshake
  assign s1_adv   = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign accept   = in_i.valid && in_i.ready;
  assign s1_vld_d = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_q);

  // operand stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ins_q <= in_i.instruction;
      s1_pc_q  <= in_i.pc;
    end
  end

  ralu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rs_addr_i (in_i.instruction[25:21]),
    .rt_addr_i (in_i.instruction[20:16]),
    .wr_i      (commit),
    .rs_data_o (rs_data),
    .rt_data_o (rt_data)
  );

  ralu_exec u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_adv),
    .ins_i    (s1_ins_q),
    .pc_i     (s1_pc_q),
    .a_i      (rs_data),
    .b_i      (rt_data),
    .res_o    (exec_res),
    .commit_o (commit)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q <= exec_res;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.status       = out_res_q.status;
  assign out_o.write_enable = out_res_q.write_enable;
  assign out_o.dest_reg     = out_res_q.dest_reg;
  assign out_o.write_value  = out_res_q.write_value;
  assign out_o.jump_taken   = out_res_q.jump_taken;
  assign out_o.jump_target  = out_res_q.jump_target;

  // checks
  a_wr_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_res_q.write_enable) |->
      (out_res_q.dest_reg != '0) && (out_res_q.status == StOk))
    else $error("register write reported with bad status or register 0");

  a_jump_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_res_q.jump_taken) |-> (out_res_q.status == StOk))
    else $error("jump reported on a failed item");

  a_commit_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit.we |-> (s1_adv && (commit.rd != '0)))
    else $error("register file written outside an item commit");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_adv) |=> (s1_vld_q && $stable(s1_ins_q) && $stable(s1_pc_q)))
    else $error("stalled operand-stage item lost or changed");

endmodule
